/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define CHECK_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CHECK_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dfns_pkg.sv */
// ---------------------------------------------------------------------------
// dfns_pkg
// Shared constants and helpers of the directory-first name sort unit.
// ---------------------------------------------------------------------------
package dfns_pkg;

   localparam int ENTRY_SLOTS_DEF = 64;
   localparam int NAME_LEN_DEF    = 64;

   localparam int BYTE_W = 8;
   localparam int POS_OUT_W = 6;

   localparam logic [BYTE_W-1:0] FOLD_LO     = 8'h41;
   localparam logic [BYTE_W-1:0] FOLD_HI     = 8'h5A;
   localparam logic [BYTE_W-1:0] FOLD_OFFSET = 8'd32;

   // Fold A-Z to lower case, leave every other byte as is.
   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if (c >= FOLD_LO && c <= FOLD_HI) begin
         r = c + FOLD_OFFSET;
      end
      return r;
   endfunction

endpackage

/* rtl/dfns_req_if.sv */
// ---------------------------------------------------------------------------
// dfns_req_if
// Input channel: one name byte per beat with its flags.
// ---------------------------------------------------------------------------
interface dfns_req_if
   import dfns_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] name_byte;
   logic              dir_flag;
   logic              final_entry;

   modport source  (output valid, name_byte, dir_flag, final_entry, input ready);
   modport sink    (input valid, name_byte, dir_flag, final_entry, output ready);
   modport monitor (input valid, ready, name_byte, dir_flag, final_entry);
endinterface

/* rtl/dfns_rsp_if.sv */
// ---------------------------------------------------------------------------
// dfns_rsp_if
// Result channel: one sorted entry per beat.
// ---------------------------------------------------------------------------
interface dfns_rsp_if
   import dfns_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [POS_OUT_W-1:0] load_position;
   logic                 entry_is_dir;
   logic                 run_last;

   modport source  (output valid, load_position, entry_is_dir, run_last, input ready);
   modport sink    (input valid, load_position, entry_is_dir, run_last, output ready);
   modport monitor (input valid, ready, load_position, entry_is_dir, run_last);
endinterface

/* rtl/dir_first_name_sort_unit.sv */
// ---------------------------------------------------------------------------
// dir_first_name_sort_unit
// Stable directory-first, case-folded name sort over loaded entries.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ch takes one name byte per beat; a zero byte closes the entry and
//    carries dir_flag; final_entry on that zero byte starts the sort.
//  - Loading accepts one beat per cycle. Bytes beyond NAME_LEN-1 and
//    entries beyond ENTRY_SLOTS are dropped.
//  - After the final terminator, req_ch.ready stays low while an insertion
//    sort runs over the order memory. Each compare step reads both names
//    one byte per cycle from the dual-read name memory, stopping at the
//    first differing byte, a zero byte or the last name byte; when the
//    directory flags differ they decide with no name read. The shift or
//    insert is written in the final compare state. Fetching the held entry
//    takes ST_SORT_RDI and ST_SORT_HLD in each outer pass. Worst case is
//    about ENTRY_SLOTS^2/2 compares of up to NAME_LEN bytes.
//  - rsp_ch then gives one beat per entry in sorted order, run_last on the
//    last; the next entry is read only after a beat is taken, and the output
//    register holds while rsp_ch.ready is low.
//  - After the last beat is taken the block is ready for a new run.
//  - Reset clears counters and the output valid; no memory clearing pass.
// ---------------------------------------------------------------------------
module dir_first_name_sort_unit
   import dfns_pkg::*;
#(
   parameter int ENTRY_SLOTS = ENTRY_SLOTS_DEF,
   parameter int NAME_LEN    = NAME_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dfns_req_if.sink   req_ch,
   dfns_rsp_if.source rsp_ch
);
   localparam int IDX_W = $clog2(ENTRY_SLOTS);
   localparam int CNT_W = $clog2(ENTRY_SLOTS + 1);
   localparam int POS_W = $clog2(NAME_LEN);
   localparam int NA_W  = $clog2(ENTRY_SLOTS * NAME_LEN);
   localparam int ORD_W = IDX_W + 1;

   typedef enum logic [7:0] {
      ST_LOAD     = 8'b0000_0001,
      ST_SORT_RDI = 8'b0000_0010,
      ST_SORT_HLD = 8'b0000_0100,
      ST_SORT_J   = 8'b0000_1000,
      ST_SORT_CND = 8'b0001_0000,
      ST_SORT_CMP = 8'b0010_0000,
      ST_EMIT_RD  = 8'b0100_0000,
      ST_EMIT_WT  = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [POS_W-1:0]   k_ff, k_in;
   logic [IDX_W-1:0]   e_ff, e_in;
   logic [ORD_W-1:0]   held_ff, held_in;
   logic [ORD_W-1:0]   cand_ff, cand_in;
   logic               out_valid_ff, out_valid_in;
   logic [POS_OUT_W-1:0] out_pos_ff, out_pos_in;
   logic               out_dir_ff, out_dir_in;
   logic               out_last_ff, out_last_in;

   // memory ports
   logic               nm_wr_en;
   logic [NA_W-1:0]    nm_wr_addr;
   logic [BYTE_W-1:0]  nm_wr_data;
   logic [IDX_W-1:0]   nm_idx_a, nm_idx_b;
   logic [POS_W-1:0]   nm_k;
   logic [NA_W-1:0]    nm_rd_addr_a, nm_rd_addr_b;
   logic [BYTE_W-1:0]  nm_rd_data_a, nm_rd_data_b;
   logic               om_wr_en;
   logic [IDX_W-1:0]   om_wr_addr, om_rd_addr;
   logic [ORD_W-1:0]   om_wr_data, om_rd_data;

   logic               req_beat, rsp_beat, full;
   logic [CNT_W-1:0]   count_next;
   logic [BYTE_W-1:0]  fold_a, fold_b;
   logic               i_done;

   assign req_beat = req_ch.valid && req_ch.ready;
   assign rsp_beat = rsp_ch.valid && rsp_ch.ready;
   assign full     = (count_ff == CNT_W'(ENTRY_SLOTS));
   assign fold_a   = fold_byte(nm_rd_data_a);
   assign fold_b   = fold_byte(nm_rd_data_b);
   // last outer pass reached: i+1 equals entry count
   assign i_done   = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);

   assign nm_rd_addr_a = NA_W'(nm_idx_a) * NA_W'(NAME_LEN) + NA_W'(nm_k);
   assign nm_rd_addr_b = NA_W'(nm_idx_b) * NA_W'(NAME_LEN) + NA_W'(nm_k);

   assign req_ch.ready         = (state_ff == ST_LOAD);
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.load_position = out_pos_ff;
   assign rsp_ch.entry_is_dir  = out_dir_ff;
   assign rsp_ch.run_last      = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      held_in      = held_ff;
      cand_in      = cand_ff;
      out_valid_in = out_valid_ff;
      out_pos_in   = out_pos_ff;
      out_dir_in   = out_dir_ff;
      out_last_in  = out_last_ff;
      count_next   = count_ff;

      nm_wr_en   = 1'b0;
      nm_wr_addr = NA_W'(count_ff[IDX_W-1:0]) * NA_W'(NAME_LEN) + NA_W'(pos_ff);
      nm_wr_data = req_ch.name_byte;
      nm_idx_a   = held_ff[IDX_W-1:0];
      nm_idx_b   = cand_ff[IDX_W-1:0];
      nm_k       = k_ff;
      om_wr_en   = 1'b0;
      om_wr_addr = j_ff;
      om_wr_data = held_ff;
      om_rd_addr = i_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               if (req_ch.name_byte != '0) begin
                  // store the byte unless the name or the table is full
                  if (!full && (pos_ff != POS_W'(NAME_LEN - 1))) begin
                     nm_wr_en = 1'b1;
                     pos_in   = pos_ff + POS_W'(1);
                  end
               end else begin
                  if (!full) begin
                     nm_wr_en   = 1'b1;
                     om_wr_en   = 1'b1;
                     om_wr_addr = count_ff[IDX_W-1:0];
                     om_wr_data = {req_ch.dir_flag, count_ff[IDX_W-1:0]};
                     count_next = count_ff + CNT_W'(1);
                  end
                  count_in = count_next;
                  pos_in   = '0;
                  if (req_ch.final_entry) begin
                     if (count_next == CNT_W'(1)) begin
                        e_in     = '0;
                        state_in = ST_EMIT_RD;
                     end else begin
                        i_in     = IDX_W'(1);
                        state_in = ST_SORT_RDI;
                     end
                  end
               end
            end
         end
         ST_SORT_RDI: begin
            om_rd_addr = i_ff;
            state_in   = ST_SORT_HLD;
         end
         ST_SORT_HLD: begin
            held_in  = om_rd_data;
            j_in     = i_ff;
            state_in = ST_SORT_J;
         end
         ST_SORT_J: begin
            if (j_ff == '0) begin
               // insert held at the front
               om_wr_en   = 1'b1;
               om_wr_addr = j_ff;
               om_wr_data = held_ff;
               if (i_done) begin
                  e_in     = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_SORT_RDI;
               end
            end else begin
               om_rd_addr = j_ff - IDX_W'(1);
               state_in   = ST_SORT_CND;
            end
         end
         ST_SORT_CND: begin
            cand_in = om_rd_data;
            if (om_rd_data[IDX_W] != held_ff[IDX_W]) begin
               // group decides: a directory goes first
               if (held_ff[IDX_W]) begin
                  om_wr_en   = 1'b1;
                  om_wr_data = om_rd_data;
                  j_in       = j_ff - IDX_W'(1);
                  state_in   = ST_SORT_J;
               end else begin
                  om_wr_en   = 1'b1;
                  om_wr_data = held_ff;
                  if (i_done) begin
                     e_in     = '0;
                     state_in = ST_EMIT_RD;
                  end else begin
                     i_in     = i_ff + IDX_W'(1);
                     state_in = ST_SORT_RDI;
                  end
               end
            end else begin
               nm_idx_b = om_rd_data[IDX_W-1:0];
               nm_k     = '0;
               k_in     = '0;
               state_in = ST_SORT_CMP;
            end
         end
         ST_SORT_CMP: begin
            if ((fold_a != fold_b && fold_a < fold_b)) begin
               // held goes before cand: shift cand up
               om_wr_en   = 1'b1;
               om_wr_data = cand_ff;
               j_in       = j_ff - IDX_W'(1);
               state_in   = ST_SORT_J;
            end else if (fold_a != fold_b || fold_a == '0 ||
                         k_ff == POS_W'(NAME_LEN - 1)) begin
               om_wr_en   = 1'b1;
               om_wr_data = held_ff;
               if (i_done) begin
                  e_in     = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_SORT_RDI;
               end
            end else begin
               nm_k = k_ff + POS_W'(1);
               k_in = k_ff + POS_W'(1);
            end
         end
         ST_EMIT_RD: begin
            om_rd_addr = e_ff;
            state_in   = ST_EMIT_WT;
         end
         ST_EMIT_WT: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               out_pos_in   = POS_OUT_W'(om_rd_data[IDX_W-1:0]);
               out_dir_in   = om_rd_data[IDX_W];
               out_last_in  = ((CNT_W'(e_ff) + CNT_W'(1)) == count_ff);
            end else if (rsp_beat) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in = '0;
                  pos_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  e_in     = e_ff + IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      e_ff        <= e_in;
      held_ff     <= held_in;
      cand_ff     <= cand_in;
      out_pos_ff  <= out_pos_in;
      out_dir_ff  <= out_dir_in;
      out_last_ff <= out_last_in;
   end

   dfns_name_mem #(
      .DEPTH  (ENTRY_SLOTS * NAME_LEN),
      .ADDR_W (NA_W)
   ) u_name_mem (
      .clock     (clock),
      .wr_en     (nm_wr_en),
      .wr_addr   (nm_wr_addr),
      .wr_data   (nm_wr_data),
      .rd_addr_a (nm_rd_addr_a),
      .rd_addr_b (nm_rd_addr_b),
      .rd_data_a (nm_rd_data_a),
      .rd_data_b (nm_rd_data_b)
   );

   dfns_order_mem #(
      .DEPTH  (ENTRY_SLOTS),
      .ADDR_W (IDX_W),
      .DATA_W (ORD_W)
   ) u_order_mem (
      .clock   (clock),
      .wr_en   (om_wr_en),
      .wr_addr (om_wr_addr),
      .wr_data (om_wr_data),
      .rd_addr (om_rd_addr),
      .rd_data (om_rd_data)
   );
endmodule

/* rtl/dfns_name_mem.sv */
// ---------------------------------------------------------------------------
// dfns_name_mem
// Name byte store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module dfns_name_mem
   import dfns_pkg::*;
#(
   parameter int DEPTH  = ENTRY_SLOTS_DEF * NAME_LEN_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [BYTE_W-1:0] rd_data_a,
   output logic [BYTE_W-1:0] rd_data_b
);
   logic [BYTE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

/* rtl/dfns_order_mem.sv */
// ---------------------------------------------------------------------------
// dfns_order_mem
// Order list store: {dir, load index} per sorted place, registered read.
// ---------------------------------------------------------------------------
module dfns_order_mem
   import dfns_pkg::*;
#(
   parameter int DEPTH  = ENTRY_SLOTS_DEF,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = ADDR_W + 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/dfns_checker.sv */
// ---------------------------------------------------------------------------
// dfns_checker
// Port-level checks of the sort unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dfns_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_run_last
);
   `CHECK_CLK_RST(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped while stalled")
   `CHECK_CLK_RST(a_no_load_during_emit, clock, reset,
      rsp_valid |-> !req_ready, "input taken while a result waits")
   `CHECK_CLK(a_reset_clears, clock, reset |=> !rsp_valid, "rsp valid after reset")
   `CHECK_CLK_RST(a_ready_after_run, clock, reset,
      rsp_valid && rsp_ready && rsp_run_last |=> req_ready && !rsp_valid,
      "not ready after last beat")
endmodule

bind dir_first_name_sort_unit dfns_checker u_dfns_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_run_last (rsp_ch.run_last)
);
